// ----- hdl/slc_pkg.sv -----
// Shared constants, types and helpers of the C source line classifier.
package slc_pkg;

   // Width of the running line counters; totals show their low 32 bits
   localparam int COUNT_WIDTH = 32;
   localparam int TOTAL_WIDTH = 32;

   // Line classes
   localparam logic [1:0] CLASS_EMPTY   = 2'd0;
   localparam logic [1:0] CLASS_COMMENT = 2'd1;
   localparam logic [1:0] CLASS_CODE    = 2'd2;

   // Characters of interest
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // One classified line, as produced by the scanner
   typedef struct packed {
      logic                   emit;
      logic [1:0]             line_class;
      logic [TOTAL_WIDTH-1:0] empty_total;
      logic [TOTAL_WIDTH-1:0] comment_total;
      logic [TOTAL_WIDTH-1:0] code_total;
      logic                   file_done;
   } line_result_type;

   // Comment tracking flags of the scanner
   typedef struct packed {
      logic block_comment_open;
      logic in_line_comment;
      logic pending_slash;
      logic pending_star;
   } scan_status_type;

   // Space, tab, newline, vertical tab, formfeed and return
   function automatic logic is_blank(logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_RETURN));
   endfunction

   // Low bits of a counter as a total
   function automatic logic [TOTAL_WIDTH-1:0] to_total(count_type v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[TOTAL_WIDTH-1:0];
   endfunction

   // Increment that stops at the largest value
   function automatic count_type sat_inc(count_type v);
      return (v == '1) ? v : count_type'(v + 1'b1);
   endfunction

endpackage

// ----- hdl/slc_scan.sv -----
// Comment tracking state, line classification and saturating line counters.
module slc_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               text_byte,
   input  logic                     file_end,
   output slc_pkg::line_result_type result,
   output slc_pkg::scan_status_type status
);

   logic                in_block_ff, in_block_in;
   logic                in_line_ff, in_line_in;
   logic                slash_ff, slash_in;
   logic                star_ff, star_in;
   logic                has_code_ff, has_code_in;
   logic                has_comment_ff, has_comment_in;
   slc_pkg::count_type  empty_ff, empty_in;
   slc_pkg::count_type  comment_ff, comment_in;
   slc_pkg::count_type  code_ff, code_in;

   // Work out the next state and the result for this item
   always_comb begin
      logic line_end;
      logic consumed;
      slc_pkg::count_type empty_new, comment_new, code_new;
      logic [1:0] cls;

      in_block_in    = in_block_ff;
      in_line_in     = in_line_ff;
      slash_in       = slash_ff;
      star_in        = star_ff;
      has_code_in    = has_code_ff;
      has_comment_in = has_comment_ff;
      empty_in       = empty_ff;
      comment_in     = comment_ff;
      code_in        = code_ff;
      consumed       = 1'b0;
      empty_new      = empty_ff;
      comment_new    = comment_ff;
      code_new       = code_ff;
      cls            = slc_pkg::CLASS_EMPTY;

      // Track comments
      if (in_line_ff) begin
         // ignore the rest of the line
      end else if (in_block_ff) begin
         has_comment_in = 1'b1;
         if (star_ff && (text_byte == slc_pkg::CHAR_SLASH)) begin
            in_block_in = 1'b0;
            star_in     = 1'b0;
         end else begin
            star_in = (text_byte == slc_pkg::CHAR_STAR);
         end
      end else begin
         if (slash_ff) begin
            slash_in = 1'b0;
            if (text_byte == slc_pkg::CHAR_STAR) begin
               in_block_in    = 1'b1;
               has_comment_in = 1'b1;
               star_in        = 1'b0;
               consumed       = 1'b1;
            end else if (text_byte == slc_pkg::CHAR_SLASH) begin
               in_line_in     = 1'b1;
               has_comment_in = 1'b1;
               consumed       = 1'b1;
            end else begin
               has_code_in = 1'b1;
            end
         end
         if (!consumed) begin
            if (text_byte == slc_pkg::CHAR_SLASH) begin
               slash_in = 1'b1;
            end else if (!slc_pkg::is_blank(text_byte)) begin
               has_code_in = 1'b1;
            end
         end
      end

      line_end = (text_byte == slc_pkg::CHAR_NEWLINE) || file_end;

      // Classify the line, a lone slash at its end counts as code
      if (has_code_in || slash_in) begin
         cls      = slc_pkg::CLASS_CODE;
         code_new = slc_pkg::sat_inc(code_ff);
      end else if (has_comment_in) begin
         cls         = slc_pkg::CLASS_COMMENT;
         comment_new = slc_pkg::sat_inc(comment_ff);
      end else begin
         cls       = slc_pkg::CLASS_EMPTY;
         empty_new = slc_pkg::sat_inc(empty_ff);
      end

      result.emit          = line_end;
      result.line_class    = cls;
      result.empty_total   = slc_pkg::to_total(empty_new);
      result.comment_total = slc_pkg::to_total(comment_new);
      result.code_total    = slc_pkg::to_total(code_new);
      result.file_done     = file_end;

      // Close the line, and the whole file on its last byte
      if (line_end) begin
         in_line_in     = 1'b0;
         slash_in       = 1'b0;
         star_in        = 1'b0;
         has_code_in    = 1'b0;
         has_comment_in = 1'b0;
         empty_in       = empty_new;
         comment_in     = comment_new;
         code_in        = code_new;
         if (file_end) begin
            in_block_in = 1'b0;
            empty_in    = '0;
            comment_in  = '0;
            code_in     = '0;
         end
      end
   end

   // Hold state, advance on each item taken
   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff    <= 1'b0;
         in_line_ff     <= 1'b0;
         slash_ff       <= 1'b0;
         star_ff        <= 1'b0;
         has_code_ff    <= 1'b0;
         has_comment_ff <= 1'b0;
         empty_ff       <= '0;
         comment_ff     <= '0;
         code_ff        <= '0;
      end else if (step) begin
         in_block_ff    <= in_block_in;
         in_line_ff     <= in_line_in;
         slash_ff       <= slash_in;
         star_ff        <= star_in;
         has_code_ff    <= has_code_in;
         has_comment_ff <= has_comment_in;
         empty_ff       <= empty_in;
         comment_ff     <= comment_in;
         code_ff        <= code_in;
      end
   end

   assign status.block_comment_open = in_block_ff;
   assign status.in_line_comment    = in_line_ff;
   assign status.pending_slash      = slash_ff;
   assign status.pending_star       = star_ff;

endmodule

// ----- hdl/c_source_line_classifier.sv -----
// Top level of the C source line classifier: input register, scanner, result register.
//
//   channel | direction | tdata (low bit up)                          | tlast
//   req_    | in        | text_byte[7:0]                              | file_end
//   rsp_    | out       | line_class, empty/comment/code totals, pad  | file_done
//
// One byte is taken every cycle unless a line end waits on a stalled result; each
// byte is held in the input register and its result, if any, lands in the result
// register as it steps; the scanner's flags and counters loop back to set this rate.
// A stalled result holds the input register only when that byte ends a line.
// Reset is synchronous and clears flags, counters and both valid bits.
module c_source_line_classifier (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // text_byte[7:0]
   input  logic         req_tlast,   // file_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // line_class[1:0], empty_total[33:2],
                                     // comment_total[65:34], code_total[97:66], zeros
   output logic         rsp_tlast    // file_done
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     in_last_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [1:0]               out_class_ff;
   logic [31:0]              out_empty_ff, out_comment_ff, out_code_ff;
   logic                     out_done_ff;
   logic                     out_free;
   logic                     step;
   slc_pkg::line_result_type result;
   slc_pkg::scan_status_type status;

   // Advance the held byte unless its result has nowhere to go
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && (!result.emit || out_free);
   assign req_tready = !in_valid_ff || step;

   slc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .text_byte (in_byte_ff),
      .file_end  (in_last_ff),
      .result    (result),
      .status    (status)
   );

   always_comb begin
      in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !step);
      out_valid_in = (step && result.emit) ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the incoming item and the finished result
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && result.emit) begin
         out_class_ff   <= result.line_class;
         out_empty_ff   <= result.empty_total;
         out_comment_ff <= result.comment_total;
         out_code_ff    <= result.code_total;
         out_done_ff    <= result.file_done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_code_ff, out_comment_ff, out_empty_ff, out_class_ff};
   assign rsp_tlast  = out_done_ff;

`ifndef SYNTHESIS
   // No pending slash survives inside a block comment
   assert property (@(posedge clock) disable iff (reset)
      !(status.block_comment_open && status.pending_slash))
      else $error("pending slash inside block comment");

   // A pending star exists only inside a block comment
   assert property (@(posedge clock) disable iff (reset)
      status.pending_star |-> status.block_comment_open)
      else $error("pending star outside block comment");

   // A line comment never leaves a slash pending
   assert property (@(posedge clock) disable iff (reset)
      !(status.in_line_comment && status.pending_slash))
      else $error("pending slash inside line comment");

   // A line end blocked by a full result register stays held
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && result.emit && out_valid_ff && !rsp_tready)
      |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("line end dropped while result stalled");
`endif

endmodule

// ----- test/line_class_checker.sv -----
// Checker for the line classifier: predicts each line result and compares it.
`timescale 1ns / 100ps

module line_class_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // text_byte[7:0]
   input  logic         req_tlast,   // file_end
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,   // line_class[1:0], empty_total[33:2],
                                     // comment_total[65:34], code_total[97:66], zeros
   input  logic         rsp_tlast,   // file_done
   output int           fail_count,
   output int           lines_waiting
);

   typedef struct packed {
      logic [1:0]                      line_class;
      logic [slc_pkg::TOTAL_WIDTH-1:0] empty_total;
      logic [slc_pkg::TOTAL_WIDTH-1:0] comment_total;
      logic [slc_pkg::TOTAL_WIDTH-1:0] code_total;
      logic                            file_done;
   } line_report_type;

   // Scanner state as the predictor sees it
   logic               block_open;
   logic               line_comment_open;
   logic               slash_held;
   logic               star_held;
   logic               saw_code;
   logic               saw_comment;
   slc_pkg::count_type empty_seen;
   slc_pkg::count_type comment_seen;
   slc_pkg::count_type code_seen;

   line_report_type pending_lines[$];
   int              errors;

   initial begin
      errors = 0;
   end

   function automatic slc_pkg::count_type bump(slc_pkg::count_type v);
      return (v == '1) ? v : slc_pkg::count_type'(v + 1'b1);
   endfunction

   function automatic void clear_scan();
      block_open        = 1'b0;
      line_comment_open = 1'b0;
      slash_held        = 1'b0;
      star_held         = 1'b0;
      saw_code          = 1'b0;
      saw_comment       = 1'b0;
      empty_seen        = '0;
      comment_seen      = '0;
      code_seen         = '0;
   endfunction

   // Advance the scanner by one byte; return 1 when the byte closes a line
   function automatic logic classify_byte(input logic [7:0] b, input logic last,
                                          output line_report_type rep);
      logic taken;
      logic blank;
      rep   = '0;
      taken = 1'b0;
      blank = (b == slc_pkg::CHAR_SPACE) ||
              ((b >= slc_pkg::CHAR_TAB) && (b <= slc_pkg::CHAR_RETURN));

      if (line_comment_open) begin
         // rest of the line is skipped
      end else if (block_open) begin
         saw_comment = 1'b1;
         if (star_held && b == slc_pkg::CHAR_SLASH) begin
            block_open = 1'b0;
            star_held  = 1'b0;
         end else begin
            star_held = (b == slc_pkg::CHAR_STAR);
         end
      end else begin
         if (slash_held) begin
            slash_held = 1'b0;
            if (b == slc_pkg::CHAR_STAR) begin
               block_open  = 1'b1;
               saw_comment = 1'b1;
               star_held   = 1'b0;
               taken       = 1'b1;
            end else if (b == slc_pkg::CHAR_SLASH) begin
               line_comment_open = 1'b1;
               saw_comment       = 1'b1;
               taken             = 1'b1;
            end else begin
               saw_code = 1'b1;
            end
         end
         if (!taken) begin
            if (b == slc_pkg::CHAR_SLASH)
               slash_held = 1'b1;
            else if (!blank)
               saw_code = 1'b1;
         end
      end

      if (b != slc_pkg::CHAR_NEWLINE && !last)
         return 1'b0;

      // A slash left hanging at line end counts as code
      if (slash_held)
         saw_code = 1'b1;

      if (saw_code) begin
         rep.line_class = slc_pkg::CLASS_CODE;
         code_seen = bump(code_seen);
      end else if (saw_comment) begin
         rep.line_class = slc_pkg::CLASS_COMMENT;
         comment_seen = bump(comment_seen);
      end else begin
         rep.line_class = slc_pkg::CLASS_EMPTY;
         empty_seen = bump(empty_seen);
      end
      rep.empty_total   = slc_pkg::TOTAL_WIDTH'(empty_seen);
      rep.comment_total = slc_pkg::TOTAL_WIDTH'(comment_seen);
      rep.code_total    = slc_pkg::TOTAL_WIDTH'(code_seen);
      rep.file_done     = last;

      line_comment_open = 1'b0;
      slash_held        = 1'b0;
      star_held         = 1'b0;
      saw_code          = 1'b0;
      saw_comment       = 1'b0;
      if (last)
         clear_scan();
      return 1'b1;
   endfunction

   task automatic compare_field(input string label,
                                input logic [slc_pkg::TOTAL_WIDTH-1:0] want,
                                input logic [slc_pkg::TOTAL_WIDTH-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         errors++;
      end
   endtask

   // Watch both channels at each edge
   always @(posedge clock) begin : monitor
      line_report_type want;
      line_report_type next_line;
      if (reset) begin
         clear_scan();
         pending_lines.delete();
      end else begin
         // Compare a delivered line against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (pending_lines.size() == 0) begin
               $display({"%0t: unexpected line result, expected none, ",
                         "actual class %0d totals %0d/%0d/%0d"},
                        $time, rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[65:34],
                        rsp_tdata[97:66]);
               errors++;
            end else begin
               want = pending_lines.pop_front();
               compare_field("line_class", slc_pkg::TOTAL_WIDTH'(want.line_class),
                             slc_pkg::TOTAL_WIDTH'(rsp_tdata[1:0]));
               compare_field("empty_total", want.empty_total, rsp_tdata[33:2]);
               compare_field("comment_total", want.comment_total, rsp_tdata[65:34]);
               compare_field("code_total", want.code_total, rsp_tdata[97:66]);
               compare_field("tdata padding", '0,
                             slc_pkg::TOTAL_WIDTH'(rsp_tdata[103:98]));
               compare_field("file_done", slc_pkg::TOTAL_WIDTH'(want.file_done),
                             slc_pkg::TOTAL_WIDTH'(rsp_tlast));
            end
         end
         // Predict from each accepted byte
         if (req_tvalid && req_tready) begin
            if (classify_byte(req_tdata, req_tlast, next_line))
               pending_lines.push_back(next_line);
         end
      end
      lines_waiting <= pending_lines.size();
      fail_count    <= errors;
   end

endmodule

// ----- test/tb_top.sv -----
// Top of the line classifier testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

   localparam int BYTE_TARGET = 1950;
   localparam int IDLE_LIMIT  = 3000;
   localparam int HOLD_CYCLES = 300;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tlast;

   int fail_count;
   int lines_waiting;
   int lines_seen;
   int idle_cycles;
   int bytes_sent;
   bit steady;

   logic [7:0] file_text[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   c_source_line_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   line_class_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .lines_waiting (lines_waiting)
   );

   // Mostly short gaps, now and then a long one
   function automatic int gap_length(bit allow_none);
      int r;
      r = $urandom_range(0, 99);
      if (allow_none && r < 60)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_string(input string s);
      for (int i = 0; i < s.len(); i++)
         file_text.push_back(s[i]);
   endfunction

   function automatic void add_letters(input int count);
      for (int i = 0; i < count; i++)
         file_text.push_back(8'h61 + 8'($urandom_range(0, 25)));
   endfunction

   // Append one lexical piece of C-like text
   function automatic void add_token();
      logic [7:0] b;
      case ($urandom_range(0, 15))
         0, 1, 2, 3: add_letters($urandom_range(1, 4));
         4, 5: begin
            b = 8'($urandom_range(9, 13));
            file_text.push_back((b == slc_pkg::CHAR_NEWLINE) ? slc_pkg::CHAR_SPACE : b);
         end
         6: begin
            add_string("/*");
            add_letters($urandom_range(0, 3));
            if ($urandom_range(0, 2) != 0)
               add_string("*/");
         end
         7: add_string("*/");
         8: begin
            add_string("//");
            add_letters($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0)
               add_string("*/");
         end
         9: file_text.push_back(slc_pkg::CHAR_SLASH);
         10: file_text.push_back(slc_pkg::CHAR_STAR);
         11: add_string("/*/");
         12: add_string("**/");
         13: file_text.push_back(8'($urandom_range(0, 255)));
         14: file_text.push_back(8'($urandom_range(128, 255)));
         default: begin
            file_text.push_back(slc_pkg::CHAR_SLASH);
            add_letters(1);
         end
      endcase
   endfunction

   function automatic void build_random_file();
      int line_count;
      int token_count;
      file_text.delete();
      line_count = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                               : $urandom_range(1, 8);
      for (int l = 0; l < line_count; l++) begin
         token_count = $urandom_range(0, 7);
         for (int t = 0; t < token_count; t++)
            add_token();
         // The last line may end on a plain byte instead of a newline
         if (l < line_count - 1 || $urandom_range(0, 1) == 0 || file_text.size() == 0)
            file_text.push_back(slc_pkg::CHAR_NEWLINE);
      end
   endfunction

   // Offer one byte, hold it until taken, then maybe idle
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      gap = steady ? 0 : gap_length(1'b1);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_file();
      for (int i = 0; i < file_text.size(); i++)
         send_byte(file_text[i], i == file_text.size() - 1);
   endtask

   // Count delivered lines and cycles without any transfer
   always @(posedge clock) begin
      if (reset) begin
         lines_seen  <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            lines_seen <= lines_seen + 1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off to back up the input
   initial begin : receiver
      bit held;
      int mode;
      int run_len;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && lines_seen >= 40) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode    = $urandom_range(0, 2);
         run_len = $urandom_range(10, 120);
         repeat (run_len) begin
            if (mode != 0 && $urandom_range(0, 3 * mode) == 0) begin
               rsp_tready <= 1'b0;
               repeat (gap_length(1'b0)) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int file_count;
      bytes_sent = 0;
      file_count = 0;
      steady     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lone slash, slash-star-slash, blank line in a block comment,
      // star at line end, line comment, whitespace set, high bytes, file end
      file_text.delete();
      add_string("a/\n/*/\n\n*\n/*/\n//*\n");
      file_text.push_back(slc_pkg::CHAR_TAB);
      file_text.push_back(8'h0B);
      file_text.push_back(8'h0C);
      file_text.push_back(slc_pkg::CHAR_RETURN);
      file_text.push_back(slc_pkg::CHAR_SPACE);
      file_text.push_back(slc_pkg::CHAR_NEWLINE);
      file_text.push_back(8'hFF);
      file_text.push_back(8'h80);
      file_text.push_back(8'h00);
      send_file();
      // File that ends on its newline
      file_text.delete();
      add_string("x\n");
      send_file();

      // Random files, some of them without any idling
      while (bytes_sent < BYTE_TARGET) begin
         steady = ($urandom_range(0, 3) == 0);
         build_random_file();
         send_file();
         file_count++;
         if (file_count == 12) begin
            // Pause until every line so far has come out
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (lines_waiting != 0) @(posedge clock);
         end
      end

      // Drain, then let the pipeline settle
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lines_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
